// ===== sv/grwc_pkg.sv =====
// shared constants, types and item classification for the grid ray wall cast unit
package grwc_pkg;
  localparam int MAP_DIM   = 64;
  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 6;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int CELL_W    = 2;
  localparam int POS_W     = 22;
  localparam int DIR_W     = 18;
  localparam int VC_W      = 17;
  localparam int DIST_W    = 24;
  localparam int LIM_W     = 7;
  localparam int DIVW      = 35;
  localparam int QW        = 42;
  localparam int CW        = 44;
  localparam int D2W       = 46;
  localparam int ROOT_W    = 24;
  localparam int DCNT_W    = 6;

  localparam logic [LIM_W-1:0]  MAP_DIM_L = LIM_W'(MAP_DIM);
  localparam logic [DIST_W-1:0] DIST_MAX  = {DIST_W{1'b1}};

  localparam logic [CELL_W-1:0] CELL_WALL    = 2'd1;
  localparam logic [CELL_W-1:0] CELL_OUTSIDE = 2'd3;

  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_CAST,
    KIND_DROP
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [ADDR_W-1:0]  addr;
    logic [CELL_W-1:0]  val;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [DIR_W-1:0]   dir_x;
    logic [DIR_W-1:0]   dir_y;
    logic [VC_W-1:0]    vc;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;
endpackage

// ===== sv/grwc_ifs.sv =====
// item and result channel interfaces
interface grwc_item_if;
  import grwc_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic [IDX_W-1:0]   cell_x;
  logic [IDX_W-1:0]   cell_y;
  logic [CELL_W-1:0]  cell_value;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic signed [DIR_W-1:0] dir_x;
  logic signed [DIR_W-1:0] dir_y;
  logic [VC_W-1:0]    view_cos;
  modport source (output valid, func, cell_x, cell_y, cell_value, pos_x, pos_y, dir_x, dir_y,
                  view_cos, input ready);
  modport sink (input valid, func, cell_x, cell_y, cell_value, pos_x, pos_y, dir_x, dir_y,
                view_cos, output ready);
endinterface

interface grwc_res_if;
  import grwc_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic              orient;
  logic [POS_W-1:0]  hit_x;
  logic [POS_W-1:0]  hit_y;
  logic [DIST_W-1:0] distance;
  modport source (output valid, hit, orient, hit_x, hit_y, distance, input ready);
  modport sink (input valid, hit, orient, hit_x, hit_y, distance, output ready);
endinterface

// ===== sv/grwc_ram.sv =====
// generic simple dual port ram with registered read
module grwc_ram #(
  parameter int Width = 2,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/grwc_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module grwc_div import grwc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIVW-1:0]  dividend_i,
  input  logic [DIR_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DIVW-1:0]  quot_o,
  output logic [DIR_W-1:0] rem_o
);
  logic [DIVW-1:0]   quo_q;
  logic [DIR_W-1:0]  rem_q;
  logic [DIR_W-1:0]  dvs_q;
  logic [DCNT_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [DIR_W:0]    sh, diff;
  logic              take;

  always_comb begin
    sh   = {rem_q, quo_q[DIVW-1]};
    diff = sh - {1'b0, dvs_q};
    take = sh >= {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(DIVW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVW-2:0], take};
      rem_q <= take ? diff[DIR_W-1:0] : sh[DIR_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;
endmodule

// ===== sv/grwc_front.sv =====
// front end: accepts items, classifies them and queues them for the back end
module grwc_front import grwc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  grwc_item_if.sink item_i,
  output head_t head_o,
  input  logic  pop_i
);
  item_t      fifo_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      in_item;

  assign item_i.ready = (cnt_q != 2'd2);
  assign push = item_i.valid && item_i.ready;

  always_comb begin
    in_item.addr  = {item_i.cell_y, item_i.cell_x};
    in_item.val   = item_i.cell_value;
    in_item.pos_x = item_i.pos_x;
    in_item.pos_y = item_i.pos_y;
    in_item.dir_x = item_i.dir_x;
    in_item.dir_y = item_i.dir_y;
    in_item.vc    = item_i.view_cos;
    if (item_i.func) begin
      in_item.kind = KIND_CAST;
    end else if ({1'b0, item_i.cell_x} < MAP_DIM_L && {1'b0, item_i.cell_y} < MAP_DIM_L) begin
      in_item.kind = KIND_WRITE;
    end else begin
      in_item.kind = KIND_DROP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wptr_q] <= in_item;
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = fifo_q[rptr_q];
endmodule

// ===== sv/grwc_back.sv =====
// back end: map store, two grid walks, hit choice, square root and result register
module grwc_back import grwc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  head_t            head_i,
  output logic             pop_o,
  input  logic [LIM_W-1:0] width_i,
  input  logic [LIM_W-1:0] height_i,
  grwc_res_if.source       res_o
);
  typedef enum logic [4:0] {
    S_IDLE, S_WINIT, S_MUL, S_DIV1, S_WAIT1, S_DIV2, S_WAIT2, S_CHECK, S_READ,
    S_SQX, S_SQY, S_SUM, S_NEXT, S_SEL, S_SQRT, S_SCALE, S_OUT
  } state_e;

  localparam logic signed [CW-1:0] ONE_C = CW'(1) <<< FRAC_BITS;

  state_e            state_q;
  item_t             item_q;
  logic              vert_q, apos_q, cneg_q;
  logic [LIM_W-1:0]  line_q;
  logic [VC_W-1:0]   amag_q;
  logic [DIR_W-1:0]  dmag_q, cmag_q;
  logic [DIVW-1:0]   prod_q;
  logic [QW-1:0]     q_q, qs_q;
  logic [DIR_W-1:0]  r_q, rs_q;
  logic [CW-1:0]     c_q;
  logic [POS_W-1:0]  cur_x_q, cur_y_q;
  logic [D2W-1:0]    sq1_q, sq2_q;
  logic              h_hit_q, v_hit_q;
  logic [POS_W-1:0]  h_x_q, h_y_q, v_x_q, v_y_q;
  logic [D2W-1:0]    h_d2_q, v_d2_q;
  logic [D2W-1:0]    n_q, root_q, bit_q;
  logic              sel_hit_q, sel_or_q;
  logic [POS_W-1:0]  sel_x_q, sel_y_q;
  logic [DIST_W-1:0] dist_q;
  logic              out_valid_q, out_hit_q, out_or_q;
  logic [POS_W-1:0]  out_x_q, out_y_q;
  logic [DIST_W-1:0] out_dist_q;

  // walk operands, swapped per axis
  logic [POS_W-1:0]  pa, pc;
  logic [DIR_W-1:0]  da, dc;
  logic [LIM_W-1:0]  w_eff, h_eff, lim_a, lim_c;
  logic              div_start, div_busy, div_done;
  logic [DIVW-1:0]   div_dvd, div_quot;
  logic [DIR_W-1:0]  div_rem;
  logic signed [CW-1:0] pc_ext, q_ext, c_sum, lim_fx;
  logic              in_bounds;
  logic [IDX_W-1:0]  ai, ci;
  logic [ADDR_W-1:0] raddr;
  logic [CELL_W-1:0] rdata;
  logic              ram_we;
  logic [DIR_W:0]    r_sum;
  logic              wrap;
  logic [POS_W-1:0]  line_fx;
  logic signed [POS_W:0] ex, ey;
  logic [D2W-1:0]    t_sqrt;
  logic [VC_W+ROOT_W-1:0] scaled;
  logic [VC_W+ROOT_W-FRAC_BITS-1:0] sc_int;

  always_comb begin
    w_eff = (width_i > MAP_DIM_L) ? MAP_DIM_L : width_i;
    h_eff = (height_i > MAP_DIM_L) ? MAP_DIM_L : height_i;
    pa    = vert_q ? item_q.pos_x : item_q.pos_y;
    pc    = vert_q ? item_q.pos_y : item_q.pos_x;
    da    = vert_q ? item_q.dir_x : item_q.dir_y;
    dc    = vert_q ? item_q.dir_y : item_q.dir_x;
    lim_a = vert_q ? w_eff : h_eff;
    lim_c = vert_q ? h_eff : w_eff;

    pc_ext = $signed({{(CW-POS_W){1'b0}}, pc});
    q_ext  = $signed({{(CW-QW){1'b0}}, q_q});
    c_sum  = cneg_q ? (pc_ext - q_ext) : (pc_ext + q_ext);
    lim_fx = $signed({{(CW-LIM_W-FRAC_BITS){1'b0}}, lim_c, {FRAC_BITS{1'b0}}});
    in_bounds = (c_sum >= ONE_C) && (c_sum < lim_fx) &&
                (line_q != '0) && (line_q < lim_a);
    ai    = apos_q ? line_q[IDX_W-1:0] : (line_q[IDX_W-1:0] - 1'b1);
    ci    = c_sum[FRAC_BITS+IDX_W-1:FRAC_BITS];
    raddr = vert_q ? {ci, ai} : {ai, ci};

    // exact running quotient: remainder stays below the divisor
    r_sum = {1'b0, r_q} + {1'b0, rs_q};
    wrap  = r_sum >= {1'b0, dmag_q};

    line_fx = {line_q[IDX_W-1:0], {FRAC_BITS{1'b0}}};
    ex = $signed({1'b0, cur_x_q}) - $signed({1'b0, item_q.pos_x});
    ey = $signed({1'b0, cur_y_q}) - $signed({1'b0, item_q.pos_y});

    t_sqrt = root_q + bit_q;
    scaled = root_q[ROOT_W-1:0] * item_q.vc;
    sc_int = scaled[VC_W+ROOT_W-1:FRAC_BITS];

    div_start = (state_q == S_DIV1) || (state_q == S_DIV2);
    div_dvd   = (state_q == S_DIV1) ? prod_q : {{(DIVW-DIR_W-FRAC_BITS){1'b0}}, cmag_q,
                                                {FRAC_BITS{1'b0}}};

    pop_o  = (state_q == S_IDLE) && head_i.valid;
    ram_we = pop_o && (head_i.item.kind == KIND_WRITE);
  end

  grwc_ram #(.Width(CELL_W), .Depth(1 << ADDR_W)) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (head_i.item.addr),
    .wdata_i (head_i.item.val),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  grwc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (dmag_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      vert_q      <= 1'b0;
      h_hit_q     <= 1'b0;
      v_hit_q     <= 1'b0;
    end else begin
      if (out_valid_q && res_o.ready && state_q != S_OUT) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (head_i.valid && head_i.item.kind == KIND_CAST) begin
            item_q  <= head_i.item;
            vert_q  <= 1'b0;
            h_hit_q <= 1'b0;
            v_hit_q <= 1'b0;
            state_q <= S_WINIT;
          end
        end
        S_WINIT: begin
          apos_q <= !da[DIR_W-1];
          cneg_q <= dc[DIR_W-1];
          dmag_q <= da[DIR_W-1] ? (~da + 1'b1) : da;
          cmag_q <= dc[DIR_W-1] ? (~dc + 1'b1) : dc;
          if (!da[DIR_W-1] && pa[FRAC_BITS-1:0] != '0) begin
            line_q <= {1'b0, pa[POS_W-1:FRAC_BITS]} + 1'b1;
            amag_q <= (VC_W'(1) << FRAC_BITS) - {1'b0, pa[FRAC_BITS-1:0]};
          end else begin
            line_q <= {1'b0, pa[POS_W-1:FRAC_BITS]};
            amag_q <= da[DIR_W-1] ? {1'b0, pa[FRAC_BITS-1:0]} : '0;
          end
          state_q <= (da == '0) ? S_NEXT : S_MUL;
        end
        S_MUL: begin
          prod_q  <= DIVW'(amag_q * cmag_q);
          state_q <= S_DIV1;
        end
        S_DIV1: state_q <= S_WAIT1;
        S_WAIT1: begin
          if (div_done) begin
            q_q     <= {{(QW-DIVW){1'b0}}, div_quot};
            r_q     <= div_rem;
            state_q <= S_DIV2;
          end
        end
        S_DIV2: state_q <= S_WAIT2;
        S_WAIT2: begin
          if (div_done) begin
            qs_q    <= {{(QW-DIVW){1'b0}}, div_quot};
            rs_q    <= div_rem;
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          c_q     <= c_sum;
          state_q <= in_bounds ? S_READ : S_NEXT;
        end
        S_READ: begin
          if (rdata == CELL_OUTSIDE) begin
            state_q <= S_NEXT;
          end else if (rdata == CELL_WALL) begin
            cur_x_q <= vert_q ? line_fx : c_q[POS_W-1:0];
            cur_y_q <= vert_q ? c_q[POS_W-1:0] : line_fx;
            state_q <= S_SQX;
          end else begin
            line_q  <= apos_q ? (line_q + 1'b1) : (line_q - 1'b1);
            q_q     <= q_q + qs_q + {{(QW-1){1'b0}}, wrap};
            r_q     <= wrap ? DIR_W'(r_sum - {1'b0, dmag_q}) : r_sum[DIR_W-1:0];
            state_q <= S_CHECK;
          end
        end
        S_SQX: begin
          sq1_q   <= D2W'(ex * ex);
          state_q <= S_SQY;
        end
        S_SQY: begin
          sq2_q   <= D2W'(ey * ey);
          state_q <= S_SUM;
        end
        S_SUM: begin
          if (vert_q) begin
            v_hit_q <= 1'b1;
            v_x_q   <= cur_x_q;
            v_y_q   <= cur_y_q;
            v_d2_q  <= sq1_q + sq2_q;
          end else begin
            h_hit_q <= 1'b1;
            h_x_q   <= cur_x_q;
            h_y_q   <= cur_y_q;
            h_d2_q  <= sq1_q + sq2_q;
          end
          state_q <= S_NEXT;
        end
        S_NEXT: begin
          if (!vert_q) begin
            vert_q  <= 1'b1;
            state_q <= S_WINIT;
          end else begin
            state_q <= S_SEL;
          end
        end
        S_SEL: begin
          root_q <= '0;
          bit_q  <= D2W'(1) << (D2W - 2);
          // horizontal wins a tie
          if (h_hit_q && (!v_hit_q || h_d2_q <= v_d2_q)) begin
            sel_hit_q <= 1'b1;
            sel_or_q  <= 1'b0;
            sel_x_q   <= h_x_q;
            sel_y_q   <= h_y_q;
            n_q       <= h_d2_q;
            state_q   <= S_SQRT;
          end else if (v_hit_q) begin
            sel_hit_q <= 1'b1;
            sel_or_q  <= 1'b1;
            sel_x_q   <= v_x_q;
            sel_y_q   <= v_y_q;
            n_q       <= v_d2_q;
            state_q   <= S_SQRT;
          end else begin
            sel_hit_q <= 1'b0;
            sel_or_q  <= 1'b0;
            sel_x_q   <= '0;
            sel_y_q   <= '0;
            dist_q    <= DIST_MAX;
            state_q   <= S_OUT;
          end
        end
        S_SQRT: begin
          if (bit_q == '0) begin
            state_q <= S_SCALE;
          end else begin
            if (n_q >= t_sqrt) begin
              n_q    <= n_q - t_sqrt;
              root_q <= (root_q >> 1) + bit_q;
            end else begin
              root_q <= root_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        S_SCALE: begin
          dist_q  <= (sc_int > {{(VC_W+ROOT_W-FRAC_BITS-DIST_W){1'b0}}, DIST_MAX}) ?
                     DIST_MAX : sc_int[DIST_W-1:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || res_o.ready) begin
            out_valid_q <= 1'b1;
            out_hit_q   <= sel_hit_q;
            out_or_q    <= sel_or_q;
            out_x_q     <= sel_x_q;
            out_y_q     <= sel_y_q;
            out_dist_q  <= dist_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.hit      = out_hit_q;
  assign res_o.orient   = out_or_q;
  assign res_o.hit_x    = out_x_q;
  assign res_o.hit_y    = out_y_q;
  assign res_o.distance = out_dist_q;

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider started while busy");
  a_rem_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (r_q < dmag_q)) else $error("running remainder out of range");
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT)) else $error("result without sequencer");
  a_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (line_q != '0 && line_q < MAP_DIM_L))
    else $error("walk read off the map");
endmodule

// ===== sv/grid_ray_wall_cast_unit.sv =====
// top level of the grid ray wall cast unit: register port, front end and back end
//
//  channel   dir  handshake        content
//  item_i    in   valid/ready      map cell write or ray cast
//  result_o  out  valid/ready      hit flag, orientation, contact point, distance
//  apb       in   psel/penable     map_width at 0x0, map_height at 0x4
//
// a map write is done as the item is popped; a cast runs up to four divider passes
// (start offset and step of each walk), the check and read states per grid line checked,
// the two square states and the sum state per wall found, then a square root and a scale
// step; the shortest cast is the one whose direction components are both zero
// the back end handles one item at a time; a 2-entry queue keeps input flowing
// reset clears the registers to 64 and empties queue and result register;
// map cells are undefined until written
module grid_ray_wall_cast_unit import grwc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  grwc_item_if.sink   item_i,
  grwc_res_if.source  result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [LIM_W-1:0] width_q, height_q;
  logic [1:0]       reg_idx;
  head_t            head;
  logic             pop;

  assign pready  = 1'b1;
  assign reg_idx = {1'b0, paddr[2]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= MAP_DIM_L;
      height_q <= MAP_DIM_L;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_MAP_WIDTH:  width_q  <= pwdata[LIM_W-1:0];
        REG_MAP_HEIGHT: height_q <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAP_WIDTH:  prdata = {{(32-LIM_W){1'b0}}, width_q};
      REG_MAP_HEIGHT: prdata = {{(32-LIM_W){1'b0}}, height_q};
      default:        prdata = '0;
    endcase
  end

  grwc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .head_o (head),
    .pop_i  (pop)
  );

  grwc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .width_i  (width_q),
    .height_i (height_q),
    .res_o    (result_o)
  );
endmodule

// ===== bench/grwc_cast_checker.sv =====
`timescale 1ns / 1ps
// checker that mirrors the map and registers, predicts each cast and compares results
module grwc_cast_checker import grwc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  grwc_item_if        item_i,
  grwc_res_if         result_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic              hit;
    logic              orient;
    logic [POS_W-1:0]  hit_x;
    logic [POS_W-1:0]  hit_y;
    logic [DIST_W-1:0] distance;
  } cast_res_t;

  localparam longint ONE = longint'(1) << FRAC_BITS;

  logic [CELL_W-1:0] cells [MAP_DIM*MAP_DIM];
  logic [LIM_W-1:0]  width_q, height_q;
  cast_res_t         cast_q [$];

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root, bitv;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // walk grid lines of one axis; along is the stepped axis, across the other
  function automatic bit walk_lines(input longint pa, input longint pc, input longint da,
                                    input longint dc, input longint lim_a, input longint lim_c,
                                    input bit horiz, output longint ha, output longint hc);
    longint line, c, ai, ci, row, col;
    logic [CELL_W-1:0] v;
    ha = 0;
    hc = 0;
    line = pa >>> FRAC_BITS;
    if (da > 0 && (pa & (ONE - 1)) != 0) line++;
    forever begin
      c = pc + ((line * ONE - pa) * dc) / da;
      if (!(c >= ONE && c < lim_c * ONE && line >= 1 && line < lim_a)) return 1'b0;
      ai = (da > 0) ? line : line - 1;
      ci = c >>> FRAC_BITS;
      row = horiz ? ai : ci;
      col = horiz ? ci : ai;
      v = cells[row * MAP_DIM + col];
      if (v == CELL_OUTSIDE) return 1'b0;
      if (v == CELL_WALL) begin
        ha = line * ONE;
        hc = c;
        return 1'b1;
      end
      line += (da > 0) ? 1 : -1;
    end
  endfunction

  function automatic cast_res_t predict_cast(input logic [POS_W-1:0] px_v,
                                             input logic [POS_W-1:0] py_v,
                                             input logic signed [DIR_W-1:0] dx_v,
                                             input logic signed [DIR_W-1:0] dy_v,
                                             input logic [VC_W-1:0] vc_v);
    cast_res_t r;
    longint px, py, dx, dy, w, h, hxa, hxc, vxa, vxc, ex, ey;
    longint unsigned hd2, vd2, d2, d;
    bit hh, vh;
    px = longint'(px_v);
    py = longint'(py_v);
    dx = longint'(dx_v);
    dy = longint'(dy_v);
    w = (width_q > MAP_DIM_L) ? MAP_DIM : longint'(width_q);
    h = (height_q > MAP_DIM_L) ? MAP_DIM : longint'(height_q);
    hh = 0;
    vh = 0;
    hxa = 0; hxc = 0; vxa = 0; vxc = 0;
    hd2 = 0; vd2 = 0; d2 = 0;
    if (dy != 0) hh = walk_lines(py, px, dy, dx, h, w, 1'b1, hxa, hxc);
    if (dx != 0) vh = walk_lines(px, py, dx, dy, w, h, 1'b0, vxa, vxc);
    if (hh) begin
      ex = hxc - px; ey = hxa - py;
      hd2 = ex * ex + ey * ey;
    end
    if (vh) begin
      ex = vxa - px; ey = vxc - py;
      vd2 = ex * ex + ey * ey;
    end
    r = '0;
    r.distance = DIST_MAX;
    // horizontal keeps a tie
    if (hh && (!vh || hd2 <= vd2)) begin
      r.hit = 1'b1; r.orient = 1'b0;
      r.hit_x = POS_W'(hxc); r.hit_y = POS_W'(hxa); d2 = hd2;
    end else if (vh) begin
      r.hit = 1'b1; r.orient = 1'b1;
      r.hit_x = POS_W'(vxa); r.hit_y = POS_W'(vxc); d2 = vd2;
    end
    if (r.hit) begin
      d = (int_sqrt(d2) * longint'(vc_v)) >> FRAC_BITS;
      r.distance = (d > longint'(DIST_MAX)) ? DIST_MAX : DIST_W'(d);
    end
    return r;
  endfunction

  initial begin
    fail_count_o = 0;
    width_q = MAP_DIM_L;
    height_q = MAP_DIM_L;
  end

  assign pending_o = cast_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    cast_res_t e, a;
    if (!rst_ni) begin
      width_q = MAP_DIM_L;
      height_q = MAP_DIM_L;
      cast_q.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == 3'(int'(REG_MAP_WIDTH) * 4)) width_q = pwdata_i[LIM_W-1:0];
        else if (paddr_i == 3'(int'(REG_MAP_HEIGHT) * 4)) height_q = pwdata_i[LIM_W-1:0];
      end
      if (item_i.valid && item_i.ready) begin
        if (item_i.func == 1'b0)
          cells[int'(item_i.cell_y) * MAP_DIM + int'(item_i.cell_x)] = item_i.cell_value;
        else
          cast_q.push_back(predict_cast(item_i.pos_x, item_i.pos_y, item_i.dir_x,
                                        item_i.dir_y, item_i.view_cos));
      end
      if (result_i.valid && result_i.ready) begin
        a = '{result_i.hit, result_i.orient, result_i.hit_x, result_i.hit_y,
              result_i.distance};
        if (cast_q.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, a);
          fail_count_o++;
        end else begin
          e = cast_q.pop_front();
          if (a.hit !== e.hit) begin
            $display("%0t: hit expected %0d actual %0d", $time, e.hit, a.hit);
            fail_count_o++;
          end
          if (a.orient !== e.orient) begin
            $display("%0t: orient expected %0d actual %0d", $time, e.orient, a.orient);
            fail_count_o++;
          end
          if (a.hit_x !== e.hit_x) begin
            $display("%0t: hit_x expected %h actual %h", $time, e.hit_x, a.hit_x);
            fail_count_o++;
          end
          if (a.hit_y !== e.hit_y) begin
            $display("%0t: hit_y expected %h actual %h", $time, e.hit_y, a.hit_y);
            fail_count_o++;
          end
          if (a.distance !== e.distance) begin
            $display("%0t: distance expected %h actual %h", $time, e.distance, a.distance);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_grid_ray_wall_cast_unit.sv =====
`timescale 1ns / 1ps
// testbench top: map fill, directed and random casts, register phases and verdict
module tb_grid_ray_wall_cast_unit;
  import grwc_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;
  localparam int     SETTLE      = 500;
  // random casts that read the map run with both bounds at most this, so only this corner is filled
  localparam int     FILL        = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          hold_req = 0, hold_done = 0;
  int          burst_left = 0;
  longint      cycles = 0;

  grwc_item_if item_if();
  grwc_res_if  res_if();

  grid_ray_wall_cast_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n), .item_i(item_if), .result_o(res_if),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  grwc_cast_checker i_checker (
    .clk_i(clk), .rst_ni(rst_n), .item_i(item_if), .result_i(res_if),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    item_if.valid = 1'b0;
    item_if.func = 1'b0;
    item_if.cell_x = '0;
    item_if.cell_y = '0;
    item_if.cell_value = '0;
    item_if.pos_x = '0;
    item_if.pos_y = '0;
    item_if.dir_x = '0;
    item_if.dir_y = '0;
    item_if.view_cos = '0;
    res_if.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** grid_ray_wall_cast_unit: FAILED **");
      $finish;
    end
  end

  // receiver: stall pattern redrawn at random from four modes, with a long hold-off on request
  initial begin : result_sink
    int mode, cnt;
    mode = 0;
    cnt = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        res_if.ready <= 1'b0;
        repeat (600) @(negedge clk);
        hold_done = hold_req;
      end else begin
        if (cnt == 0) begin
          mode = $urandom_range(0, 3);
          cnt = 64;
        end
        cnt--;
        case (mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= ($urandom_range(0, 1) == 1);
          2: res_if.ready <= ($urandom_range(0, 9) == 0);
          default: res_if.ready <= (cnt[3:0] < 4'd12);
        endcase
      end
    end
  end

  task automatic send_item(input logic func, input int cx, input int cy, input int cv,
                           input int px, input int py, input int dx, input int dy,
                           input int vc);
    bit acc;
    int gap;
    @(negedge clk);
    item_if.valid <= 1'b1;
    item_if.func <= func;
    item_if.cell_x <= IDX_W'(cx);
    item_if.cell_y <= IDX_W'(cy);
    item_if.cell_value <= CELL_W'(cv);
    item_if.pos_x <= POS_W'(px);
    item_if.pos_y <= POS_W'(py);
    item_if.dir_x <= DIR_W'(dx);
    item_if.dir_y <= DIR_W'(dy);
    item_if.view_cos <= VC_W'(vc);
    forever begin
      #0.5 acc = item_if.ready;
      @(posedge clk);
      if (acc) break;
    end
    // bursts with random gaps; some bursts run long with no gaps at all
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        @(negedge clk);
        item_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input int value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(int'(idx) * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    item_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic int rand_cell();
    int r;
    r = $urandom_range(0, 99);
    if (r < 72) return 0;
    if (r < 86) return 1;
    if (r < 95) return 2;
    return 3;
  endfunction

  function automatic int rand_dir();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(0, 262143) - 131072;
    return $urandom_range(0, 131072) - 65536;
  endfunction

  function automatic int rand_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return $urandom_range(0, 4194303);
    if (r < 4) return $urandom_range(1, FILL - 2) << FRAC_BITS;
    return ($urandom_range(1, FILL - 2) << FRAC_BITS) | $urandom_range(0, 65535);
  endfunction

  function automatic int rand_vc();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 131071);
    if (r == 1) return 65536;
    return $urandom_range(20000, 65536);
  endfunction

  task automatic random_items(input int n);
    repeat (n) begin
      if ($urandom_range(0, 9) < 4)
        send_item(1'b0, $urandom_range(0, FILL - 1), $urandom_range(0, FILL - 1), rand_cell(),
                  0, 0, 0, 0, 0);
      else
        send_item(1'b1, 0, 0, 0, rand_pos(), rand_pos(), rand_dir(), rand_dir(), rand_vc());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every cell inside the bounds used by reading casts gets written first
    for (int y = 0; y < FILL; y++)
      for (int x = 0; x < FILL; x++)
        send_item(1'b0, x, y, rand_cell(), 0, 0, 0, 0, 0);
    drain();

    // default registers: axis rays that stay on one row or column of the filled corner
    send_item(1'b0, 11, 10, 1, 0, 0, 0, 0, 0);
    send_item(1'b1, 0, 0, 0, (10 << 16) + 32768, (10 << 16) + 32768, 65536, 0, 65536);
    send_item(1'b1, 0, 0, 0, (10 << 16) + 32768, (10 << 16) + 32768, -65536, 0, 65536);
    send_item(1'b1, 0, 0, 0, (10 << 16) + 32768, (10 << 16) + 32768, 0, -65536, 65536);
    send_item(1'b1, 0, 0, 0, (10 << 16) + 32768, (10 << 16) + 32768, 0, 0, 65536);
    drain();

    write_reg(REG_MAP_WIDTH, FILL);
    write_reg(REG_MAP_HEIGHT, FILL);

    // directed: extremes, axis rays, zero direction, tie on a corner, sprites and outside
    send_item(1'b0, 10, 10, 1, 0, 0, 0, 0, 0);
    send_item(1'b1, 0, 0, 0, 10 << 16, 10 << 16, 65536, 65536, 65536);
    send_item(1'b1, 0, 0, 0, 10 << 16, 10 << 16, 0, 0, 65536);
    send_item(1'b1, 0, 0, 0, 0, 0, 65536, 65536, 65536);
    send_item(1'b1, 0, 0, 0, 4194303, 4194303, -65536, -65536, 131071);
    send_item(1'b1, 0, 0, 0, 5 << 16, 15 << 16, 65536, 0, 65536);
    send_item(1'b1, 0, 0, 0, 5 << 16, 15 << 16, -65536, 0, 0);
    send_item(1'b1, 0, 0, 0, 5 << 16, 15 << 16, 0, 65536, 65536);
    send_item(1'b1, 0, 0, 0, (5 << 16) + 1, (15 << 16) + 65535, 0, -65536, 65536);
    send_item(1'b1, 0, 0, 0, 12 << 16, 12 << 16, 131071, -131072, 65536);
    send_item(1'b1, 0, 0, 0, 12 << 16, 12 << 16, -131072, 131071, 131071);
    send_item(1'b0, 14, 14, 2, 0, 0, 0, 0, 0);
    send_item(1'b0, 17, 14, 3, 0, 0, 0, 0, 0);
    send_item(1'b1, 0, 0, 0, (12 << 16) + 32768, (14 << 16) + 32768, 65536, 0, 65536);
    send_item(1'b0, 19, 19, 1, 0, 0, 0, 0, 0);
    send_item(1'b0, 63, 63, 1, 0, 0, 0, 0, 0);
    send_item(1'b0, 0, 0, 3, 0, 0, 0, 0, 0);
    send_item(1'b1, 0, 0, 0, 18 << 16, 18 << 16, 1, 1, 1);
    send_item(1'b1, 0, 0, 0, 1 << 16, 1 << 16, -1, -1, 65536);
    drain();

    // long receiver hold-off while input keeps coming
    random_items(150);
    hold_req = 1;
    random_items(150);
    drain();

    write_reg(REG_MAP_WIDTH, 127);
    write_reg(REG_MAP_HEIGHT, 1);
    random_items(80);
    drain();

    write_reg(REG_MAP_WIDTH, 0);
    write_reg(REG_MAP_HEIGHT, 64);
    random_items(60);
    drain();

    write_reg(REG_MAP_WIDTH, 13);
    write_reg(REG_MAP_HEIGHT, 19);
    random_items(200);
    drain();

    write_reg(REG_MAP_WIDTH, 1);
    write_reg(REG_MAP_HEIGHT, 127);
    random_items(60);
    drain();

    write_reg(REG_MAP_WIDTH, FILL);
    write_reg(REG_MAP_HEIGHT, FILL - 1);
    random_items(130);
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("** grid_ray_wall_cast_unit: PASSED **");
    end else begin
      $display("** grid_ray_wall_cast_unit: FAILED **");
    end
    $finish;
  end

endmodule
